### rtl/sme_pkg.sv
// Package: shared types, constants and codes for the stack machine executor.
`default_nettype none
package sme_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int CALL_DEPTH   = 16;
    localparam int MEMORY_WORDS = 256;

    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int SC_W  = $clog2(STACK_DEPTH + 1);
    localparam int RP_W  = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam int RC_W  = $clog2(CALL_DEPTH + 1);
    localparam int MA_W  = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;

    typedef enum logic [4:0] {
        CMD_PUSH = 5'd0,  CMD_POP = 5'd1,  CMD_STORE = 5'd2, CMD_LOAD = 5'd3,
        CMD_ADD  = 5'd4,  CMD_SUB = 5'd5,  CMD_MUL   = 5'd6, CMD_DIV  = 5'd7,
        CMD_MOD  = 5'd8,  CMD_CMP = 5'd9,  CMD_JMP   = 5'd10, CMD_JZ  = 5'd11,
        CMD_JNZ  = 5'd12, CMD_JL  = 5'd13, CMD_JLE   = 5'd14, CMD_JG  = 5'd15,
        CMD_JGE  = 5'd16, CMD_CALL = 5'd17, CMD_RET  = 5'd18, CMD_NOP = 5'd19
    } t_cmd;

    typedef enum logic [3:0] {
        ERR_OK = 4'd0, ERR_UNDER = 4'd1, ERR_OVER = 4'd2, ERR_ADDR = 4'd3,
        ERR_TARGET = 4'd4, ERR_RET = 4'd5, ERR_CALL = 4'd6, ERR_CMD = 4'd7,
        ERR_DIV0 = 4'd8
    } t_err;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_WRITE, ST_OUT
    } t_state;

    typedef struct packed {
        logic [4:0]         command;
        logic signed [31:0] operand;
    } t_in;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               halted;
        logic [3:0]         error_code;
        logic signed [31:0] top_value;
        logic [6:0]         stack_count;
    } t_out;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

endpackage
`default_nettype wire

### rtl/sme_div.sv
// Module: signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module sme_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sme_pkg::t_div_req i_req,
    output sme_pkg::t_div_rsp     o_rsp
);
    import sme_pkg::*;

    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [31:0] r_q;
    logic [32:0] r_r;
    logic [31:0] r_d;
    logic        r_qneg;
    logic        r_rneg;
    logic [32:0] n_r;
    logic [32:0] w_diff;

    always_comb begin
        n_r    = {r_r[31:0], r_q[31]};
        w_diff = n_r - {1'b0, r_d};
    end

    // iterate restoring division on magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_q    <= i_req.dividend[31] ? 32'(-i_req.dividend) : i_req.dividend;
                r_d    <= i_req.divisor[31] ? 32'(-i_req.divisor) : i_req.divisor;
                r_r    <= '0;
                r_qneg <= i_req.dividend[31] ^ i_req.divisor[31];
                r_rneg <= i_req.dividend[31];
            end else if (r_busy) begin
                if (w_diff[32]) begin
                    r_r <= n_r;
                    r_q <= {r_q[30:0], 1'b0};
                end else begin
                    r_r <= w_diff;
                    r_q <= {r_q[30:0], 1'b1};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_qneg ? 32'(-r_q) : r_q;
    assign o_rsp.rem  = r_rneg ? 32'(-r_r[31:0]) : r_r[31:0];
endmodule
`default_nettype wire

### rtl/stack_machine_execute.sv
// Top level: stack machine instruction executor with memory-held stacks and data.
`default_nettype none
// One instruction is taken per transaction and yields one result transaction.
// Each instruction reads the top two stack entries from the value stack memory
// (two read ports, registered reads), then executes and writes back. A plain
// instruction passes through the read, execute, write back and output states
// before its result reaches the output register, and the next instruction is
// accepted only once the machine is idle again. Div and mod also wait in a
// divide state for the bit-serial divider. The result waits in an output
// register, so a stalled receiver holds only the instruction behind it: that
// one executes and then waits until the result ahead of it is taken. After
// reset a clearing pass sweeps the data memory, one word per cycle, while no
// instruction is accepted.
module stack_machine_execute (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire sme_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output sme_pkg::t_out     o_data,
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata
);
    import sme_pkg::*;

    // memories
    logic [31:0] r_vstack [STACK_DEPTH];
    logic [15:0] r_rstack [CALL_DEPTH];
    logic [31:0] r_dmem   [MEMORY_WORDS];

    t_state      r_state, n_state;
    logic [SC_W-1:0] r_vcnt;
    logic [RC_W-1:0] r_rcnt;
    logic [15:0] r_pc;
    logic [15:0] r_plen;
    logic        r_clr;
    logic [MA_W:0] r_clr_idx;
    t_in         r_in;
    logic [31:0] r_a, r_b, r_m;
    logic [15:0] r_ret;
    logic [31:0] r_res;
    logic [31:0] r_top;
    t_out        r_pend;
    t_out        r_out;
    logic        r_ovalid;
    logic        r_halt_q;

    // write-back plan computed in EXEC
    logic [3:0]  r_err;
    logic        r_vwe;
    logic [SP_W-1:0] r_vwa;
    logic [SC_W-1:0] r_vcnt_n;
    logic [RC_W-1:0] r_rcnt_n;
    logic        r_dwe;
    logic [15:0] r_pc_n;
    logic        r_topsel;  // top from written value

    t_div_req    w_dreq;
    t_div_rsp    w_drsp;

    sme_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    wire w_accept = i_valid && o_ready;
    wire w_halt   = r_pc >= r_plen;
    wire w_out_move = (r_state == ST_OUT) && (!r_ovalid || i_ready);
    wire [SC_W-1:0] w_c1 = r_vcnt - SC_W'(1);
    wire [SC_W-1:0] w_c2 = r_vcnt - SC_W'(2);
    wire w_addr_ok = !r_in.operand[31] && (r_in.operand < 32'(MEMORY_WORDS));
    wire w_tgt_ok  = !r_in.operand[31] && (r_in.operand[30:0] < 31'(r_plen));

    assign o_ready = (r_state == ST_IDLE) && !r_clr;

    // state register and control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vcnt    <= '0;
            r_rcnt    <= '0;
            r_pc      <= '0;
            r_plen    <= '0;
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_plen <= i_cfg_wdata;
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + (MA_W+1)'(1);
                if (r_clr_idx == (MA_W+1)'(MEMORY_WORDS - 1)) r_clr <= 1'b0;
            end
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (r_state == ST_WRITE) begin
                r_vcnt <= r_vcnt_n;
                r_rcnt <= r_rcnt_n;
                r_pc   <= r_pc_n;
            end
            if (w_out_move) r_ovalid <= 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_READ;
            ST_READ:  n_state = ST_EXEC;
            ST_EXEC:  n_state = w_dreq.start ? ST_DIV : ST_WRITE;
            ST_DIV:   if (w_drsp.done) n_state = ST_WRITE;
            ST_WRITE: n_state = ST_OUT;
            ST_OUT:   if (w_out_move) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory reads (registered)
    always_ff @(posedge i_clk) begin
        if (w_accept) r_in <= i_data;
        if (r_state == ST_READ) begin
            r_a   <= r_vstack[w_c1[SP_W-1:0]];
            r_b   <= r_vstack[w_c2[SP_W-1:0]];
            r_m   <= r_dmem[r_in.operand[MA_W-1:0]];
            r_ret <= r_rstack[r_rcnt[RP_W-1:0] - RP_W'(1)];
        end
    end

    always_ff @(posedge i_clk) if (r_state == ST_READ) r_halt_q <= w_halt;

    wire w_div = (r_in.command == CMD_DIV || r_in.command == CMD_MOD) && !r_halt_q
                 && r_vcnt >= SC_W'(2) && r_a != 32'd0;

    assign w_dreq.start    = (r_state == ST_EXEC) && w_div;
    assign w_dreq.dividend = r_b;
    assign w_dreq.divisor  = r_a;

    // execute: decide error and write-back
    logic [3:0]  x_err;
    logic        x_vwe, x_dwe, x_topsel, x_rwe;
    logic [SP_W-1:0] x_vwa;
    logic [SC_W-1:0] x_vcnt;
    logic [RC_W-1:0] x_rcnt;
    logic [15:0] x_next;
    logic [31:0] x_res;
    logic        x_tst;

    always_comb begin
        x_err = ERR_OK; x_vwe = 1'b0; x_dwe = 1'b0; x_topsel = 1'b0; x_rwe = 1'b0;
        x_vwa = r_vcnt[SP_W-1:0]; x_vcnt = r_vcnt; x_rcnt = r_rcnt;
        x_next = r_pc + 16'd1; x_res = r_in.operand;
        x_tst = 1'b0;
        case (r_in.command)
            CMD_PUSH: begin
                if (r_vcnt >= SC_W'(STACK_DEPTH)) x_err = ERR_OVER;
                else begin x_vwe = 1'b1; x_vcnt = r_vcnt + SC_W'(1); x_topsel = 1'b1; end
            end
            CMD_POP: begin
                if (r_vcnt == '0) x_err = ERR_UNDER;
                else x_vcnt = w_c1;
            end
            CMD_STORE: begin
                if (r_vcnt == '0) x_err = ERR_UNDER;
                else if (!w_addr_ok) x_err = ERR_ADDR;
                else begin x_dwe = 1'b1; x_vcnt = w_c1; end
            end
            CMD_LOAD: begin
                if (!w_addr_ok) x_err = ERR_ADDR;
                else if (r_vcnt >= SC_W'(STACK_DEPTH)) x_err = ERR_OVER;
                else begin
                    x_vwe = 1'b1; x_vcnt = r_vcnt + SC_W'(1); x_topsel = 1'b1; x_res = r_m;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_CMP: begin
                if (r_vcnt < SC_W'(2)) x_err = ERR_UNDER;
                else if ((r_in.command == CMD_DIV || r_in.command == CMD_MOD)
                         && r_a == 32'd0) x_err = ERR_DIV0;
                else begin
                    x_vwe = 1'b1; x_vwa = w_c2[SP_W-1:0]; x_vcnt = w_c1; x_topsel = 1'b1;
                    case (r_in.command)
                        CMD_ADD: x_res = r_b + r_a;
                        CMD_MUL: x_res = r_b * r_a;
                        default: x_res = r_b - r_a;
                    endcase
                end
            end
            CMD_JMP: begin
                if (!w_tgt_ok) x_err = ERR_TARGET;
                else x_next = r_in.operand[15:0];
            end
            CMD_JZ, CMD_JNZ, CMD_JL, CMD_JLE, CMD_JG, CMD_JGE: begin
                case (r_in.command)
                    CMD_JZ:  x_tst = r_a == 32'd0;
                    CMD_JNZ: x_tst = r_a != 32'd0;
                    CMD_JL:  x_tst = r_a[31];
                    CMD_JLE: x_tst = r_a[31] || r_a == 32'd0;
                    CMD_JG:  x_tst = !r_a[31] && r_a != 32'd0;
                    default: x_tst = !r_a[31];
                endcase
                if (r_vcnt == '0) x_err = ERR_UNDER;
                else if (x_tst && !w_tgt_ok) x_err = ERR_TARGET;
                else begin
                    x_vcnt = w_c1;
                    if (x_tst) x_next = r_in.operand[15:0];
                end
            end
            CMD_CALL: begin
                if (!w_tgt_ok) x_err = ERR_TARGET;
                else if (r_rcnt >= RC_W'(CALL_DEPTH)) x_err = ERR_CALL;
                else begin
                    x_rwe = 1'b1; x_rcnt = r_rcnt + RC_W'(1); x_next = r_in.operand[15:0];
                end
            end
            CMD_RET: begin
                if (r_rcnt == '0) x_err = ERR_RET;
                else begin x_rcnt = r_rcnt - RC_W'(1); x_next = r_ret; end
            end
            CMD_NOP: ;
            default: x_err = ERR_CMD;
        endcase
        if (r_halt_q) begin
            x_err = ERR_OK; x_vwe = 1'b0; x_dwe = 1'b0; x_rwe = 1'b0; x_topsel = 1'b0;
            x_vcnt = r_vcnt; x_rcnt = r_rcnt; x_next = r_pc;
        end else if (x_err != ERR_OK) begin
            x_vwe = 1'b0; x_dwe = 1'b0; x_rwe = 1'b0; x_topsel = 1'b0;
            x_vcnt = r_vcnt; x_rcnt = r_rcnt; x_next = r_pc;
        end
    end

    logic r_rwe;
    // hold the write-back plan; a shrinking stack exposes the second entry
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_err <= x_err; r_vwe <= x_vwe; r_dwe <= x_dwe; r_rwe <= x_rwe;
            r_topsel <= x_topsel; r_vwa <= x_vwa; r_vcnt_n <= x_vcnt;
            r_rcnt_n <= x_rcnt; r_pc_n <= x_next; r_res <= x_res;
            r_top <= r_b;
        end else if (r_state == ST_DIV && w_drsp.done) begin
            r_res <= (r_in.command == CMD_DIV) ? w_drsp.quot : w_drsp.rem;
        end
    end

    // write back memories
    always_ff @(posedge i_clk) begin
        if (r_clr) r_dmem[r_clr_idx[MA_W-1:0]] <= '0;
        else if (r_state == ST_WRITE && r_dwe) r_dmem[r_in.operand[MA_W-1:0]] <= r_a;
        if (r_state == ST_WRITE && r_vwe) r_vstack[r_vwa] <= r_res;
        if (r_state == ST_WRITE && r_rwe) r_rstack[r_rcnt[RP_W-1:0]] <= r_pc + 16'd1;
    end

    // form the result, then move it to the output register once that is free
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_pend.next_pc     <= r_pc_n;
            r_pend.halted      <= r_pc_n >= r_plen;
            r_pend.error_code  <= r_err;
            r_pend.stack_count <= 7'(r_vcnt_n);
            if (r_vcnt_n == '0)   r_pend.top_value <= '0;
            else if (r_topsel)    r_pend.top_value <= r_res;
            else if (r_vcnt_n == r_vcnt) r_pend.top_value <= r_a;
            else                  r_pend.top_value <= r_top;
        end
        if (w_out_move) r_out <= r_pend;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // no transaction accepted during the clearing pass
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_ready) else $error("accept during clear");
    // halted state leaves the program counter unchanged
    a_halt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && r_halt_q) |=> (r_pc == $past(r_pc)))
        else $error("pc moved while halted");
    // stack count stays in range
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= SC_W'(STACK_DEPTH)) else $error("stack count out of range");
    // hold a waiting result steady
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result changed while waiting");
endmodule
`default_nettype wire
